[rtl/slk_pkg.sv]
// ============================================================================
// slk_pkg - shared types and constants of the stereo soft-knee limiter
// Fixed-point constants (Q0.23 / Q1.15), register index codes and the
// sequencer state type.
// ============================================================================
package slk_pkg;

    // Q0.23 full scale and the knee width (0.1 in Q0.23)
    localparam int          Q_W      = 24;
    localparam logic [23:0] Q23_ONE  = 24'd8388608;
    localparam logic [23:0] KNEE_Q23 = 24'd838861;

    // register reset values
    localparam logic [23:0] ATTACK_RESET  = 24'd83886;
    localparam logic [23:0] RELEASE_RESET = 24'd839;
    localparam logic [15:0] VOL_ONE       = 16'd32768;

    // knee divisor 20 * knee^2, used by the shared divider
    localparam int          DEN_W    = 44;
    localparam logic [43:0] KNEE_DEN = 44'(64'd20 * 64'd838861 * 64'd838861);

    // divider: one quotient bit per cycle
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = 5;

    // configuration write port
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD      = 3'd0,
        CFG_VOLUME         = 3'd1,
        CFG_LIMIT_ENABLE   = 3'd2,
        CFG_MONITOR_ENABLE = 3'd3,
        CFG_ATTACK_COEFF   = 3'd4,
        CFG_RELEASE_COEFF  = 3'd5,
        CFG_MONO_HOST      = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VOL_L,
        ST_VOL_R,
        ST_PEAK,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_GAIN_SEL,
        ST_KNEE_MUL,
        ST_KNEE_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_MIX,
        ST_OUT
    } state_t;

endpackage

[rtl/stereo_soft_knee_limiter_core.sv]
// ============================================================================
// stereo_soft_knee_limiter_core - stereo volume, soft-knee limiter, monitor mix
// Scales a wet stereo frame by the main volume, runs a peak envelope follower
// and a soft-knee gain stage, adds the dry pair and saturates the result.
// ============================================================================
//
//  channel   signals                                      beat
//  -------   -------------------------------------------  ----------------------
//  input     in_valid / in_ready, wet_*, dry_*            one stereo frame
//  output    out_valid / out_ready, out_left/right/mono   one saturated frame
//  config    cfg_we, cfg_index, cfg_data                  one register write
//
//  Frame time (accept to ready again) depends on the path: shortest with the
//  limiter off, longer below the knee and above the threshold, longest in the
//  knee. The restoring divider and the single shared multiplier set it.
//  Reset clears the sequencer, the envelope, the output valid and loads the
//  register defaults. A frame is accepted only in idle; a finished frame waits
//  in the sequencer until the output register is free, while the output
//  register itself holds a beat under back pressure.
//
module stereo_soft_knee_limiter_core
    import slk_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] wet_left,
    input  logic signed [SAMPLE_BITS-1:0] wet_right,
    input  logic signed [SAMPLE_BITS-1:0] dry_left,
    input  logic signed [SAMPLE_BITS-1:0] dry_right,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic signed [SAMPLE_BITS-1:0] out_mono
);

    localparam int SB  = SAMPLE_BITS;
    // shared multiplier: A carries samples, 25-bit envelope terms or the knee
    // distance, B the 25-bit signed view of volume, coefficient, gain or knee distance
    localparam int AW  = (SAMPLE_BITS > 25) ? SAMPLE_BITS : 25;
    localparam int BW  = 25;
    localparam int PW  = AW + BW;
    // magnitude to Q0.23 conversion width
    localparam int PKW = SAMPLE_BITS + 25;
    // divider dividend (knee distance squared or 9*thr + env) and remainder widths
    localparam int XW  = 40;
    localparam int RW  = DEN_W + 1;

    // ------------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------------
    state_t                  state_reg, state_next;

    logic [23:0]             thr_reg;
    logic [15:0]             vol_reg;
    logic                    lim_en_reg;
    logic                    mon_en_reg;
    logic [23:0]             att_reg;
    logic [23:0]             rel_reg;
    logic                    mono_reg;
    logic [23:0]             env_reg;

    logic signed [SB-1:0]    wl_reg, wr_reg, dl_reg, dr_reg;
    logic [23:0]             pk_reg;
    logic                    att_sel_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    knee_reg;
    logic [RW-1:0]           rem_reg;
    logic [23:0]             lo_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [23:0]             q_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [23:0]             gain_reg;

    logic                    out_valid_reg;
    logic signed [SB-1:0]    out_left_reg, out_right_reg, out_mono_reg;

    logic                    in_fire;
    logic                    out_slot_free;
    logic                    out_load;
    logic                    div_last;

    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_sh15;
    logic signed [PW-1:0]    prod_sh23;

    logic [SB:0]             abs_l, abs_r, pk_mag;
    logic [PKW-1:0]          pk_wide;
    logic [23:0]             pk_q23;

    logic signed [25:0]      env_diff;
    logic signed [PW-1:0]    env_step;
    logic signed [26:0]      env_sum;
    logic [23:0]             env_new;

    logic                    above_thr;
    logic                    in_knee;
    logic signed [25:0]      knee_d;
    logic [26:0]             sum_9;
    logic [26:0]             den_10;
    logic [XW-1:0]           div_x;

    logic [RW-1:0]           rem_sh;
    logic                    rem_ge;

    logic signed [SB:0]      mix_l, mix_r, mono_sum;
    logic signed [SB-1:0]    sat_l, sat_r;
    logic signed [SB-1:0]    s_max, s_min;

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    assign in_fire       = in_valid && in_ready;
    assign out_slot_free = !out_valid_reg || out_ready;
    assign div_last      = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_mono  = out_mono_reg;

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_VOL_L;
                end
            end
            ST_VOL_L:     state_next = ST_VOL_R;
            ST_VOL_R:     state_next = lim_en_reg ? ST_PEAK : ST_MIX;
            ST_PEAK:      state_next = ST_ENV_MUL;
            ST_ENV_MUL:   state_next = ST_ENV_UPD;
            ST_ENV_UPD:   state_next = ST_GAIN_SEL;
            ST_GAIN_SEL:
            begin
                if (above_thr)
                begin
                    state_next = ST_DIV;
                end
                else if (in_knee)
                begin
                    state_next = ST_KNEE_MUL;
                end
                else
                begin
                    state_next = ST_GAIN_L;
                end
            end
            ST_KNEE_MUL:  state_next = ST_KNEE_LOAD;
            ST_KNEE_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:   state_next = ST_GAIN_L;
            ST_GAIN_L:    state_next = ST_GAIN_R;
            ST_GAIN_R:    state_next = ST_MIX;
            ST_MIX:       state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: outputs (handshake and shared multiplier operands)
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_VOL_L:
            begin
                mul_a = AW'(wl_reg);
                mul_b = BW'($signed({1'b0, vol_reg}));
            end
            ST_VOL_R:
            begin
                mul_a = AW'(wr_reg);
                mul_b = BW'($signed({1'b0, vol_reg}));
            end
            ST_ENV_MUL:
            begin
                mul_a = AW'(env_diff);
                mul_b = att_sel_reg ? BW'($signed({1'b0, att_reg}))
                                    : BW'($signed({1'b0, rel_reg}));
            end
            ST_KNEE_MUL:
            begin
                mul_a = AW'($signed({1'b0, knee_d[19:0]}));
                mul_b = BW'($signed({1'b0, knee_d[19:0]}));
            end
            ST_GAIN_L:
            begin
                mul_a = AW'(wl_reg);
                mul_b = BW'($signed({1'b0, gain_reg}));
            end
            ST_GAIN_R:
            begin
                mul_a = AW'(wr_reg);
                mul_b = BW'($signed({1'b0, gain_reg}));
            end
            ST_OUT:
            begin
                out_load = out_slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // shared multiplier, products truncated toward minus infinity
    // ------------------------------------------------------------------------
    assign prod      = PW'(mul_a) * PW'(mul_b);
    assign prod_sh15 = prod >>> 15;
    assign prod_sh23 = prod >>> 23;

    // ------------------------------------------------------------------------
    // peak of |L| and |R|, moved to Q0.23 by a fixed shift
    // ------------------------------------------------------------------------
    assign abs_l   = wl_reg[SB-1] ? ((SB+1)'(0) - {wl_reg[SB-1], wl_reg}) : {1'b0, wl_reg};
    assign abs_r   = wr_reg[SB-1] ? ((SB+1)'(0) - {wr_reg[SB-1], wr_reg}) : {1'b0, wr_reg};
    assign pk_mag  = (abs_l > abs_r) ? abs_l : abs_r;
    assign pk_wide = (PKW'(pk_mag) << 24) >> SB;
    assign pk_q23  = pk_wide[23:0];

    // ------------------------------------------------------------------------
    // envelope follower: step rounded to nearest, then clamped to [0, 1]
    // ------------------------------------------------------------------------
    assign env_diff = $signed({2'b00, pk_reg}) - $signed({2'b00, env_reg});
    assign env_step = (prod_reg + PW'(signed'(32'sd4194304))) >>> 23;
    assign env_sum  = $signed({3'b000, env_reg}) + 27'(env_step);

    always_comb
    begin
        if (env_sum < 0)
        begin
            env_new = '0;
        end
        else if (env_sum > $signed({3'b000, Q23_ONE}))
        begin
            env_new = Q23_ONE;
        end
        else
        begin
            env_new = env_sum[23:0];
        end
    end

    // ------------------------------------------------------------------------
    // gain region and divider operands
    // Above threshold: gain = (9*thr + env) * 2^23 / (10*env).
    // Knee: reduction = d^2 * 2^23 / (20 * knee^2), d = env - thr + knee.
    // Both dividends have the form X * 2^23.
    // ------------------------------------------------------------------------
    assign above_thr = env_reg > thr_reg;
    assign knee_d    = $signed({2'b00, env_reg}) + $signed({2'b00, KNEE_Q23})
                     - $signed({2'b00, thr_reg});
    assign in_knee   = knee_d > 0;
    assign sum_9     = (27'(thr_reg) << 3) + 27'(thr_reg) + 27'(env_reg);
    assign den_10    = (27'(env_reg) << 3) + (27'(env_reg) << 1);
    assign div_x     = (state_reg == ST_KNEE_LOAD) ? prod_reg[XW-1:0] : XW'(sum_9);

    // restoring step: shift in one dividend bit, subtract when it fits
    assign rem_sh = {rem_reg[RW-2:0], lo_reg[23]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // ------------------------------------------------------------------------
    // monitor mix and saturation
    // ------------------------------------------------------------------------
    assign s_max = {1'b0, {(SB-1){1'b1}}};
    assign s_min = {1'b1, {(SB-1){1'b0}}};

    assign mix_l = (SB+1)'(wl_reg) + (mon_en_reg ? (SB+1)'(dl_reg) : (SB+1)'(0));
    assign mix_r = (SB+1)'(wr_reg) + (mon_en_reg ? (SB+1)'(dr_reg) : (SB+1)'(0));

    assign sat_l = (mix_l[SB] != mix_l[SB-1]) ? (mix_l[SB] ? s_min : s_max) : mix_l[SB-1:0];
    assign sat_r = (mix_r[SB] != mix_r[SB-1]) ? (mix_r[SB] ? s_min : s_max) : mix_r[SB-1:0];

    // floor of the average: the sum carries one extra bit, drop its LSB
    assign mono_sum = (SB+1)'(wl_reg) + (SB+1)'(wr_reg);

    // ------------------------------------------------------------------------
    // control state: sequencer, registers, envelope, output valid
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= Q23_ONE;
            vol_reg       <= VOL_ONE;
            lim_en_reg    <= 1'b0;
            mon_en_reg    <= 1'b0;
            att_reg       <= ATTACK_RESET;
            rel_reg       <= RELEASE_RESET;
            mono_reg      <= 1'b0;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes saturate values above full scale
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:
                        thr_reg <= (cfg_data[23:0] > Q23_ONE) ? Q23_ONE : cfg_data[23:0];
                    CFG_VOLUME:
                        vol_reg <= (cfg_data[15:0] > VOL_ONE) ? VOL_ONE : cfg_data[15:0];
                    CFG_LIMIT_ENABLE:
                        lim_en_reg <= cfg_data[0];
                    CFG_MONITOR_ENABLE:
                        mon_en_reg <= cfg_data[0];
                    CFG_ATTACK_COEFF:
                        att_reg <= (cfg_data[23:0] > Q23_ONE) ? Q23_ONE : cfg_data[23:0];
                    CFG_RELEASE_COEFF:
                        rel_reg <= (cfg_data[23:0] > Q23_ONE) ? Q23_ONE : cfg_data[23:0];
                    CFG_MONO_HOST:
                        mono_reg <= cfg_data[0];
                    default:
                        mono_reg <= mono_reg;
                endcase
            end

            if (state_reg == ST_ENV_UPD)
            begin
                env_reg <= env_new;
            end

            // hold the beat until taken; a new frame may land the same cycle
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    wl_reg <= wet_left;
                    wr_reg <= wet_right;
                    dl_reg <= dry_left;
                    dr_reg <= mono_reg ? dry_left : dry_right;
                end
            end
            ST_VOL_L:
            begin
                wl_reg <= prod_sh15[SB-1:0];
            end
            ST_VOL_R:
            begin
                wr_reg <= prod_sh15[SB-1:0];
            end
            ST_PEAK:
            begin
                pk_reg      <= pk_q23;
                att_sel_reg <= pk_q23 > env_reg;
            end
            ST_GAIN_SEL:
            begin
                // unity unless a division follows
                gain_reg <= Q23_ONE;
                knee_reg <= 1'b0;
                rem_reg  <= RW'(div_x >> 1);
                lo_reg   <= {div_x[0], 23'd0};
                den_reg  <= DEN_W'(den_10);
                cnt_reg  <= '0;
            end
            ST_KNEE_LOAD:
            begin
                knee_reg <= 1'b1;
                rem_reg  <= RW'(div_x >> 1);
                lo_reg   <= {div_x[0], 23'd0};
                den_reg  <= KNEE_DEN;
                cnt_reg  <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                lo_reg  <= {lo_reg[22:0], 1'b0};
                q_reg   <= {q_reg[22:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DIV_END:
            begin
                gain_reg <= knee_reg ? (Q23_ONE - q_reg) : q_reg;
            end
            ST_GAIN_L:
            begin
                wl_reg <= prod_sh23[SB-1:0];
            end
            ST_GAIN_R:
            begin
                wr_reg <= prod_sh23[SB-1:0];
            end
            ST_MIX:
            begin
                wl_reg <= sat_l;
                wr_reg <= sat_r;
            end
            default:
            begin
                pk_reg <= pk_reg;
            end
        endcase

        if (out_load)
        begin
            out_left_reg  <= wl_reg;
            out_right_reg <= wr_reg;
            out_mono_reg  <= mono_sum[SB:1];
        end
    end

endmodule

[dv/tb_stereo_soft_knee_limiter_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_stereo_soft_knee_limiter_core - self-checking bench of the limiter core
// Drives stereo frames through the valid/ready input, collects the saturated
// output beats and compares each one with a cycle-free fixed-point predictor
// of volume, envelope follower, soft-knee gain and monitor mix. Registers are
// reprogrammed between phases while the core is idle; both sides idle and
// stall in random bursts in most phases and never in the closing phase.
// ============================================================================
module tb_stereo_soft_knee_limiter_core;
    import slk_pkg::*;

    localparam int    SAMPLE_BITS = 24;
    localparam int    RAND_PHASES = 9;
    localparam int    PHASE_FRAMES = 110;
    localparam int    DRAIN_CYCLES = 48;        // longer than one frame on the slowest, knee path
    localparam longint FULL_SCALE = Q23_ONE;    // Q0.23 one
    localparam longint KNEE_WIDTH = KNEE_Q23;   // 0.1 in Q0.23
    localparam longint VOL_UNITY  = VOL_ONE;    // Q1.15 one
    localparam longint ROUND_HALF = 64'd4194304; // half an LSB before the >>> 23

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t wet_left;
        sample_t wet_right;
        sample_t dry_left;
        sample_t dry_right;
    } frame_t;

    typedef struct {
        sample_t left;
        sample_t right;
        sample_t mono;
    } mix_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] threshold;
        logic [CFG_DATA_W-1:0] volume;
        logic [CFG_DATA_W-1:0] limit_en;
        logic [CFG_DATA_W-1:0] monitor_en;
        logic [CFG_DATA_W-1:0] attack;
        logic [CFG_DATA_W-1:0] decay;
        logic [CFG_DATA_W-1:0] mono_host;
    } reg_set_t;

    // ------------------------------------------------------------------------
    // Limiter predictor and output scoreboard. Holds its own register copy and
    // envelope; every accepted frame pushes exactly one expected mix.
    // ------------------------------------------------------------------------
    class limiter_scoreboard;
        longint thr;
        longint vol;
        longint atk;
        longint dcy;
        bit     lim_on;
        bit     mon_on;
        bit     mono_dry;
        longint env;
        mix_t   expected_mix[$];
        int     errors;

        function new();
            thr      = FULL_SCALE;
            vol      = VOL_UNITY;
            atk      = ATTACK_RESET;
            dcy      = RELEASE_RESET;
            lim_on   = 1'b0;
            mon_on   = 1'b0;
            mono_dry = 1'b0;
            env      = 0;
            errors   = 0;
        endfunction

        static function longint clip_q23(logic [CFG_DATA_W-1:0] data);
            longint v;
            v = data;
            return (v > FULL_SCALE) ? FULL_SCALE : v;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            longint v16;
            v16 = data[15:0];
            case (idx)
                CFG_THRESHOLD:      thr = clip_q23(data);
                CFG_VOLUME:         vol = (v16 > VOL_UNITY) ? VOL_UNITY : v16;
                CFG_LIMIT_ENABLE:   lim_on = data[0];
                CFG_MONITOR_ENABLE: mon_on = data[0];
                CFG_ATTACK_COEFF:   atk = clip_q23(data);
                CFG_RELEASE_COEFF:  dcy = clip_q23(data);
                CFG_MONO_HOST:      mono_dry = data[0];
                default: ;
            endcase
        endfunction

        // Advance the envelope toward the peak and return the Q0.23 gain.
        function longint envelope_gain(longint peak);
            longint coeff;
            longint d;
            coeff = (peak > env) ? atk : dcy;
            env = env + (((peak - env) * coeff + ROUND_HALF) >>> 23);
            if (env < 0)
                env = 0;
            if (env > FULL_SCALE)
                env = FULL_SCALE;
            if (env > thr)
                return ((9 * thr + env) <<< 23) / (10 * env);
            if (env > thr - KNEE_WIDTH)
            begin
                d = env - thr + KNEE_WIDTH;
                return FULL_SCALE - (d * d * FULL_SCALE) / (20 * KNEE_WIDTH * KNEE_WIDTH);
            end
            return FULL_SCALE;
        endfunction

        function void accept_frame(frame_t f);
            longint wl;
            longint wr;
            longint dl;
            longint dr;
            longint al;
            longint ar;
            longint g;
            longint l;
            longint r;
            mix_t   m;
            wl = f.wet_left;
            wr = f.wet_right;
            dl = f.dry_left;
            dr = mono_dry ? dl : longint'(f.dry_right);
            if (vol < VOL_UNITY)
            begin
                wl = (wl * vol) >>> 15;
                wr = (wr * vol) >>> 15;
            end
            if (lim_on)
            begin
                al = (wl < 0) ? -wl : wl;
                ar = (wr < 0) ? -wr : wr;
                g  = envelope_gain((al > ar) ? al : ar);
                wl = (wl * g) >>> 23;
                wr = (wr * g) >>> 23;
            end
            if (mon_on)
            begin
                wl = wl + dl;
                wr = wr + dr;
            end
            l = (wl > 8388607) ? 8388607 : ((wl < -8388608) ? -8388608 : wl);
            r = (wr > 8388607) ? 8388607 : ((wr < -8388608) ? -8388608 : wr);
            m.left  = l;
            m.right = r;
            m.mono  = (l + r) >>> 1;
            expected_mix.push_back(m);
        endfunction

        function void check_output(sample_t l, sample_t r, sample_t mo);
            mix_t e;
            if (expected_mix.size() == 0)
            begin
                $error("output beat with no frame outstanding: L=%0d R=%0d M=%0d", l, r, mo);
                errors++;
                return;
            end
            e = expected_mix.pop_front();
            if (l !== e.left)
            begin
                $error("out_left: expected %0d, got %0d", e.left, l);
                errors++;
            end
            if (r !== e.right)
            begin
                $error("out_right: expected %0d, got %0d", e.right, r);
                errors++;
            end
            if (mo !== e.mono)
            begin
                $error("out_mono: expected %0d, got %0d", e.mono, mo);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic    in_valid;
    logic    in_ready;
    sample_t wet_left;
    sample_t wet_right;
    sample_t dry_left;
    sample_t dry_right;

    logic    out_valid;
    logic    out_ready;
    sample_t out_left;
    sample_t out_right;
    sample_t out_mono;

    limiter_scoreboard sb = new();
    bit                bubbles_on;  // random idling on both sides while set

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stereo_soft_knee_limiter_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .wet_left  (wet_left),
        .wet_right (wet_right),
        .dry_left  (dry_left),
        .dry_right (dry_right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_left  (out_left),
        .out_right (out_right),
        .out_mono  (out_mono)
    );

    // ------------------------------------------------------------------------
    // Output side: sample the beat on the edge where it is taken (pre-edge
    // values, so the order of processes inside the step does not matter), then
    // decide ready for the next cycle. Stalls come in bursts of random length.
    // ------------------------------------------------------------------------
    initial
    begin : output_sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_output(out_left, out_right, out_mono);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_ready <= 1'b1;
            end
            else if (bubbles_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 4);
                out_ready  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // Write one register on the next edge. Leave cfg_we high so that back-to-
    // back writes never drop and raise it in the same step; the caller lowers it.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
    endtask

    // Program every register; only called with no frame in flight.
    task automatic program_regs(reg_set_t s);
        write_reg(CFG_THRESHOLD, s.threshold);
        write_reg(CFG_VOLUME, s.volume);
        write_reg(CFG_LIMIT_ENABLE, s.limit_en);
        write_reg(CFG_MONITOR_ENABLE, s.monitor_en);
        write_reg(CFG_ATTACK_COEFF, s.attack);
        write_reg(CFG_RELEASE_COEFF, s.decay);
        write_reg(CFG_MONO_HOST, s.mono_host);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present one frame and hold it until the input beat is taken. Called in
    // the step of the previous acceptance, so valid stays up with no gap unless a random bubble drops it.
    task automatic send_frame(frame_t f);
        if (bubbles_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        wet_left  <= f.wet_left;
        wet_right <= f.wet_right;
        dry_left  <= f.dry_left;
        dry_right <= f.dry_right;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.accept_frame(f);
    endtask

    // Drop valid and wait for every expected beat; the core is idle after.
    task automatic drain;
        in_valid <= 1'b0;
        while (sb.expected_mix.size() != 0)
            @(posedge clk);
    endtask

    function automatic frame_t make_frame(sample_t wl, sample_t wr, sample_t dl, sample_t dr);
        frame_t f;
        f.wet_left  = wl;
        f.wet_right = wr;
        f.dry_left  = dl;
        f.dry_right = dr;
        return f;
    endfunction

    function automatic reg_set_t make_regs(int thr, int vol, int lim, int mon,
                                           int atk, int dcy, int mono);
        reg_set_t s;
        s.threshold  = thr;
        s.volume     = vol;
        s.limit_en   = lim;
        s.monitor_en = mon;
        s.attack     = atk;
        s.decay      = dcy;
        s.mono_host  = mono;
        return s;
    endfunction

    // Full-scale extremes, near-zero values and plain random words; random
    // words get the segment loudness shift so the envelope rises and falls.
    function automatic sample_t rand_sample(int shift);
        sample_t s;
        case ($urandom_range(0, 9))
            0:       s = 24'sh800000;
            1:       s = 24'sh7FFFFF;
            2:       s = $urandom_range(0, 2000) - 1000;
            default: s = sample_t'($urandom()) >>> shift;
        endcase
        return s;
    endfunction

    // Coefficients: zero, full scale, raw 24-bit words (often above full scale,
    // so they saturate) and mostly small values as in real use.
    function automatic logic [CFG_DATA_W-1:0] rand_coeff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return Q23_ONE;
            2:       return $urandom();
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    function automatic reg_set_t rand_regs();
        reg_set_t s;
        case ($urandom_range(0, 4))
            0:       s.threshold = '0;
            1:       s.threshold = Q23_ONE;
            2:       s.threshold = 24'hFFFFFF;
            default: s.threshold = $urandom_range(0, 8388608);
        endcase
        case ($urandom_range(0, 4))
            0:       s.volume = '0;
            1:       s.volume = VOL_ONE;
            2:       s.volume = $urandom();    // upper bits masked, often above unity
            default: s.volume = $urandom_range(0, 32768);
        endcase
        s.limit_en   = ($urandom_range(0, 3) != 0);
        s.monitor_en = $urandom_range(0, 1);
        s.attack     = rand_coeff();
        s.decay      = rand_coeff();
        s.mono_host  = $urandom_range(0, 1);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int shift;
        rst_n      = 1'b0;
        bubbles_on = 1'b1;
        cfg_we     = 1'b0;
        cfg_index  = CFG_THRESHOLD;
        cfg_data   = '0;
        in_valid   = 1'b0;
        wet_left   = '0;
        wet_right  = '0;
        dry_left   = '0;
        dry_right  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset: limiter off, unity volume.
        send_frame(make_frame(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
        send_frame(make_frame(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000));
        send_frame(make_frame(24'sh000000, 24'sh000000, 24'sh000000, 24'sh000000));
        send_frame(make_frame(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF));
        drain();

        // Zero threshold puts an empty envelope inside the knee. Volume and
        // attack above range saturate; zero release holds the envelope.
        // Mono host copies dry left; monitor sum saturates.
        program_regs(make_regs(0, 16'hFFFF, 1, 1, 24'hFFFFFF, 0, 1));
        send_frame(make_frame(24'sh000000, 24'sh000000, 24'sh123456, 24'sh654321));
        send_frame(make_frame(24'sh800000, 24'sh000001, 24'sh800000, 24'sh7FFFFF));
        send_frame(make_frame(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000));
        send_frame(make_frame(24'sh000000, 24'sh000000, 24'sh000000, 24'sh000000));
        drain();

        // Instant follower at 0.75 threshold: knee, above threshold, full
        // scale, then release back below the knee.
        program_regs(make_regs(24'h600000, VOL_ONE, 1, 0, Q23_ONE, Q23_ONE, 0));
        send_frame(make_frame(24'sh5A06E0, -24'sh2A0000, 24'sh111111, 24'sh222222));
        send_frame(make_frame(-24'sh7A1200, 24'sh100000, 24'sh000000, 24'sh000000));
        send_frame(make_frame(24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'sh000000));
        send_frame(make_frame(24'sh000064, -24'sh000064, 24'sh000000, 24'sh000000));
        drain();

        // Zero volume mutes the wet path; limiter off holds the envelope and
        // only the dry pair reaches the output.
        program_regs(make_regs(Q23_ONE, 0, 0, 1, ATTACK_RESET, RELEASE_RESET, 0));
        send_frame(make_frame(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000));
        send_frame(make_frame(24'sh800000, 24'sh7FFFFF, -24'sh000001, 24'sh000001));
        drain();

        // Half volume with the limiter back on at default coefficients.
        program_regs(make_regs(24'h400000, 16384, 1, 0, ATTACK_RESET, RELEASE_RESET, 0));
        send_frame(make_frame(24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000000));
        send_frame(make_frame(-24'sh000001, 24'sh000001, 24'sh000000, 24'sh000000));
        drain();

        // Random phases: new register set each phase, loudness changes every
        // 16 frames so the envelope attacks and releases across the knee.
        // The closing phase runs with no idling on either side.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            bubbles_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            program_regs(rand_regs());
            shift = 0;
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                if (n % 16 == 0)
                    shift = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
                send_frame(make_frame(rand_sample(shift), rand_sample(shift),
                                      rand_sample(0), rand_sample(0)));
            end
            drain();
        end

        // Let any stray beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_mix.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
